@@ src/swg_pkg.sv @@
// ----------------------------------------------------------------------------
// swg_pkg
// Types, constants and fixed-point helpers for the Swiss plane to
// geographic coordinate converter.
// ----------------------------------------------------------------------------
package swg_pkg;

  typedef logic signed [47:0] fx_t;

  typedef struct packed {
    logic [19:0] easting_m;
    logic [18:0] northing_m;
  } swg_in_t;

  typedef struct packed {
    logic [27:0]        longitude;
    logic [29:0]        latitude;
    logic signed [23:0] convergence;
  } swg_out_t;

  // complex power step: z = u + iv, current power re/im, running sums
  typedef struct packed {
    fx_t u;
    fx_t v;
    fx_t re;
    fx_t im;
    fx_t w;
    fx_t s;
    fx_t conv;
  } swg_pow_t;

  // latitude series step
  typedef struct packed {
    fx_t h;
    fx_t w;
    fx_t lonp;
    fx_t conv;
  } swg_hor_t;

  // magnitude product as four 24x24 partial products plus the sign
  typedef struct packed {
    logic        neg;
    logic [47:0] pll;
    logic [47:0] plh;
    logic [47:0] phl;
    logic [47:0] phh;
  } mpp_t;

  localparam int NPOW        = 6;
  localparam int EAST_ORIGIN = 600000;
  localparam int NORTH_ORIGIN = 200000;

  localparam fx_t LON_MAX   = 48'sd200000000;
  localparam fx_t LAT_MAX   = 48'sd900000000;
  localparam fx_t CONV_MIN  = -48'sd8388608;
  localparam fx_t CONV_MAX  = 48'sd8388607;

  localparam fx_t LON_SCALE_Q4 = 48'sd753648899;
  localparam fx_t LON_OFF_Q4   = 48'sd1190333333;
  localparam fx_t LAT_OFF_Q16  = 48'sd30770728504889;

  // power weights, Q32
  function automatic fx_t pow_wt(input logic [2:0] k);
    fx_t r;
    case (k)
      3'd0:    r = 48'sd6280794634;
      3'd1:    r = 48'sd275903083;
      3'd2:    r = 48'sd16159847;
      3'd3:    r = 48'sd1220129;
      3'd4:    r = 48'sd96673;
      3'd5:    r = 48'sd7912;
      default: r = '0;
    endcase
    return r;
  endfunction

  // latitude series, 1e-7 degree, Q16
  function automatic fx_t lat_ser(input logic [2:0] k);
    fx_t r;
    case (k)
      3'd0:    r = 48'sd2113763857839;
      3'd1:    r = -48'sd64091990000;
      3'd2:    r = 48'sd196176748;
      3'd3:    r = 48'sd64537161;
      3'd4:    r = -48'sd2635819;
      3'd5:    r = 48'sd14050;
      default: r = '0;
    endcase
    return r;
  endfunction

  // convergence weights, 1/256 units, Q16
  function automatic fx_t conv_wt(input logic [2:0] k);
    fx_t r;
    case (k)
      3'd0:    r = 48'sd304030381507;
      3'd1:    r = 48'sd13355462885;
      3'd2:    r = 48'sd1124553924;
      3'd3:    r = 48'sd81617806;
      3'd4:    r = 48'sd6380568;
      3'd5:    r = 48'sd524458;
      default: r = '0;
    endcase
    return r;
  endfunction

  // first half of a multiply: magnitudes split into 24-bit halves
  function automatic mpp_t mul_pp(input fx_t a, input fx_t b);
    logic [47:0] ua;
    logic [47:0] ub;
    mpp_t        pp;
    ua     = a[47] ? 48'(-a) : 48'(a);
    ub     = b[47] ? 48'(-b) : 48'(b);
    pp.neg = a[47] ^ b[47];
    pp.pll = ua[23:0] * ub[23:0];
    pp.plh = ua[23:0] * ub[47:24];
    pp.phl = ua[47:24] * ub[23:0];
    pp.phh = ua[47:24] * ub[47:24];
    return pp;
  endfunction

  // second half: round(|a*b| / 2^sh), ties away from zero, sign restored
  function automatic fx_t mul_fin(input mpp_t pp, input int sh);
    logic [95:0] p;
    logic [95:0] m;
    fx_t         r;
    p = {pp.phh, 48'd0} + {24'd0, pp.plh, 24'd0} + {24'd0, pp.phl, 24'd0} +
        {48'd0, pp.pll};
    m = (p + (96'd1 << (sh - 1))) >> sh;
    r = {1'b0, m[46:0]};
    return pp.neg ? -r : r;
  endfunction

  // floor((a + 2^(sh-1)) / 2^sh)
  function automatic fx_t round_shift(input fx_t a, input int sh);
    fx_t t;
    t = a + (48'sd1 <<< (sh - 1));
    return t >>> sh;
  endfunction

endpackage

@@ src/swg_pow_stage.sv @@
// ----------------------------------------------------------------------------
// swg_pow_stage
// One complex power step z^(k+1) = z * z^k, plus weighting of z^k into
// the longitude, latitude and convergence sums. Partial products are
// registered first, then sums, rounding and accumulation.
// ----------------------------------------------------------------------------
module swg_pow_stage
  import swg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic [2:0]  idx,
  input  logic        in_vld,
  input  swg_pow_t    in_d,
  output logic        out_vld,
  output swg_pow_t    out_d
);

  logic     vld_a_r;
  swg_pow_t d_a_r;
  mpp_t     ur_r;
  mpp_t     vi_r;
  mpp_t     vr_r;
  mpp_t     ui_r;
  mpp_t     wr_r;
  mpp_t     wi_r;
  mpp_t     ci_r;
  logic     vld_r;
  swg_pow_t d_r;
  swg_pow_t d_nxt;

  always_comb begin
    d_nxt      = d_a_r;
    d_nxt.re   = mul_fin(ur_r, 40) - mul_fin(vi_r, 40);
    d_nxt.im   = mul_fin(vr_r, 40) + mul_fin(ui_r, 40);
    d_nxt.w    = d_a_r.w + mul_fin(wr_r, 32);
    d_nxt.s    = d_a_r.s + mul_fin(wi_r, 32);
    d_nxt.conv = d_a_r.conv + mul_fin(ci_r, 40);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_r   <= 1'b0;
    end else if (en) begin
      vld_a_r <= in_vld;
      vld_r   <= vld_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_a_r <= in_d;
      ur_r  <= mul_pp(in_d.u, in_d.re);
      vi_r  <= mul_pp(in_d.v, in_d.im);
      vr_r  <= mul_pp(in_d.v, in_d.re);
      ui_r  <= mul_pp(in_d.u, in_d.im);
      wr_r  <= mul_pp(pow_wt(idx), in_d.re);
      wi_r  <= mul_pp(pow_wt(idx), in_d.im);
      ci_r  <= mul_pp(conv_wt(idx), in_d.im);
      d_r   <= d_nxt;
    end
  end

  assign out_vld = vld_r;
  assign out_d   = d_r;

endmodule

@@ src/swg_horner_stage.sv @@
// ----------------------------------------------------------------------------
// swg_horner_stage
// One step of the latitude series: h = c[k] + h*w, with partial
// products registered first, then sum and rounding.
// ----------------------------------------------------------------------------
module swg_horner_stage
  import swg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic [2:0]  idx,
  input  logic        in_vld,
  input  swg_hor_t    in_d,
  output logic        out_vld,
  output swg_hor_t    out_d
);

  logic     vld_a_r;
  swg_hor_t d_a_r;
  mpp_t     hw_r;
  logic     vld_r;
  swg_hor_t d_r;
  swg_hor_t d_nxt;

  always_comb begin
    d_nxt   = d_a_r;
    d_nxt.h = lat_ser(idx) + mul_fin(hw_r, 40);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_r   <= 1'b0;
    end else if (en) begin
      vld_a_r <= in_vld;
      vld_r   <= vld_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_a_r <= in_d;
      hw_r  <= mul_pp(in_d.h, in_d.w);
      d_r   <= d_nxt;
    end
  end

  assign out_vld = vld_r;
  assign out_d   = d_r;

endmodule

@@ src/swiss_plane_to_geographic.sv @@
// ----------------------------------------------------------------------------
// swiss_plane_to_geographic
// Swiss plane coordinates to longitude, latitude and convergence,
// fixed-point polynomial scheme in a fully pipelined datapath.
// ----------------------------------------------------------------------------
//  channel | ports                       | payload
//  --------+-----------------------------+--------------------------------
//  input   | in_valid / in_ready         | in_data  (easting_m, northing_m)
//  result  | out_valid / out_ready       | out_data (longitude, latitude,
//          |                             |           convergence)
//
//  One request per cycle while the output is not stalled. From acceptance
//  to result: offset stage, six power/weighting stages, the longitude
//  product and series seed, five series stages, the last series product,
//  and the rounding/saturating output.
//  Every multiply is split: 24-bit partial products, then sum and round.
//  Synchronous active-low reset clears all valid bits.
//  A result held at the output freezes the whole pipe; nothing is lost.
// ----------------------------------------------------------------------------
module swiss_plane_to_geographic
  import swg_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  swg_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output swg_out_t out_data
);

  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // offset stage
  logic     s0_vld_r;
  swg_pow_t s0_r;
  swg_pow_t s0_nxt;

  always_comb begin
    s0_nxt      = '0;
    s0_nxt.u    = (fx_t'(in_data.northing_m) - fx_t'(NORTH_ORIGIN)) <<< 21;
    s0_nxt.v    = (fx_t'(in_data.easting_m) - fx_t'(EAST_ORIGIN)) <<< 21;
    s0_nxt.re   = s0_nxt.u;
    s0_nxt.im   = s0_nxt.v;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (en) begin
      s0_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_r <= s0_nxt;
    end
  end

  // power chain
  logic     pw_vld [0:NPOW];
  swg_pow_t pw_d   [0:NPOW];

  assign pw_vld[0] = s0_vld_r;
  assign pw_d[0]   = s0_r;

  for (genvar k = 0; k < NPOW; k++) begin : g_pow
    swg_pow_stage u_pow (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .idx     (3'(k)),
      .in_vld  (pw_vld[k]),
      .in_d    (pw_d[k]),
      .out_vld (pw_vld[k+1]),
      .out_d   (pw_d[k+1])
    );
  end

  // longitude partial products, convergence rounding
  logic     ha_vld_r;
  fx_t      ha_w_r;
  fx_t      ha_conv_r;
  mpp_t     ha_lon_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ha_vld_r <= 1'b0;
    end else if (en) begin
      ha_vld_r <= pw_vld[NPOW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ha_w_r    <= pw_d[NPOW].w;
      ha_conv_r <= round_shift(pw_d[NPOW].conv, 16);
      ha_lon_r  <= mul_pp(pw_d[NPOW].s, LON_SCALE_Q4);
    end
  end

  // series seed, longitude product
  logic     hs_vld_r;
  swg_hor_t hs_r;
  swg_hor_t hs_nxt;

  always_comb begin
    hs_nxt.h    = lat_ser(3'(NPOW - 1));
    hs_nxt.w    = ha_w_r;
    hs_nxt.lonp = mul_fin(ha_lon_r, 40);
    hs_nxt.conv = ha_conv_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hs_vld_r <= 1'b0;
    end else if (en) begin
      hs_vld_r <= ha_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hs_r <= hs_nxt;
    end
  end

  logic     hr_vld [0:NPOW-1];
  swg_hor_t hr_d   [0:NPOW-1];

  assign hr_vld[0] = hs_vld_r;
  assign hr_d[0]   = hs_r;

  for (genvar k = 0; k < NPOW - 1; k++) begin : g_hor
    swg_horner_stage u_hor (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .idx     (3'(NPOW - 2 - k)),
      .in_vld  (hr_vld[k]),
      .in_d    (hr_d[k]),
      .out_vld (hr_vld[k+1]),
      .out_d   (hr_d[k+1])
    );
  end

  // last series product
  logic     fa_vld_r;
  swg_hor_t fa_r;
  mpp_t     fa_hw_r;
  logic     fp_vld_r;
  swg_hor_t fp_r;
  swg_hor_t fp_nxt;

  always_comb begin
    fp_nxt   = fa_r;
    fp_nxt.h = mul_fin(fa_hw_r, 40);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fa_vld_r <= 1'b0;
      fp_vld_r <= 1'b0;
    end else if (en) begin
      fa_vld_r <= hr_vld[NPOW-1];
      fp_vld_r <= fa_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fa_r    <= hr_d[NPOW-1];
      fa_hw_r <= mul_pp(hr_d[NPOW-1].h, hr_d[NPOW-1].w);
      fp_r    <= fp_nxt;
    end
  end

  // rounding and saturation
  fx_t      lon;
  fx_t      lat;
  fx_t      lon_c;
  fx_t      lat_c;
  fx_t      conv_c;
  logic     out_valid_r;
  swg_out_t out_r;
  swg_out_t out_nxt;

  always_comb begin
    lon    = round_shift(fp_r.lonp + LON_OFF_Q4, 4);
    lat    = round_shift(fp_r.h + LAT_OFF_Q16, 16);
    lon_c  = (lon < 0) ? '0 : ((lon > LON_MAX) ? LON_MAX : lon);
    lat_c  = (lat < 0) ? '0 : ((lat > LAT_MAX) ? LAT_MAX : lat);
    conv_c = (fp_r.conv < CONV_MIN) ? CONV_MIN :
             ((fp_r.conv > CONV_MAX) ? CONV_MAX : fp_r.conv);
    out_nxt.longitude   = lon_c[27:0];
    out_nxt.latitude    = lat_c[29:0];
    out_nxt.convergence = conv_c[23:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= fp_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // pipe freezes while a result is held
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("request accepted while output stalled");

  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.longitude <= 28'd200000000) &&
                  (out_data.latitude <= 30'd900000000))
    else $error("result outside saturation range");

  a_stall_holds_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule
